### sv/bdq_pkg.sv
// Shared types and constants for the bounded double-ended queue.
`timescale 1ns / 1ps
`default_nettype none
package bdq_pkg;

  localparam int VALUE_W = 32;
  localparam int CAP_W   = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Operation codes carried with each request.
  typedef enum logic [1:0] {
    ACT_PUSH_FRONT = 2'd0,
    ACT_PUSH_BACK  = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_POP_BACK   = 2'd3
  } action_t;

  // Sequencer states: take a request, wait for the memory read, deliver.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DONE
  } state_t;

  // Flags of one result, as produced by the controller.
  typedef struct packed {
    logic ok;
    logic is_empty;
    logic is_full;
  } status_t;

endpackage
`default_nettype wire

### sv/bdq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### sv/bdq_ctrl.sv
// Pointer, count and capacity control with the request sequencer.
`timescale 1ns / 1ps
`default_nettype none
module bdq_ctrl
  import bdq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic                                       clk,
  input  wire logic                                       rst,
  input  wire logic                                       cfg_wen,
  input  wire logic [CAP_W-1:0]                           cfg_wdata,
  input  wire logic                                       req_valid,
  output logic                                            req_ready,
  input  wire action_t                                    req_action,
  input  wire logic [VALUE_W-1:0]                         req_value,
  output logic                                            mem_we,
  output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]      mem_waddr,
  output logic [VALUE_W-1:0]                              mem_wdata,
  output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]      front_addr,
  output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]      rear_addr,
  output logic                                            res_valid,
  input  wire logic                                       res_taken,
  output status_t                                         res_status
);

  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [AW-1:0]    LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CMP_W-1:0] DEPTH_C  = CMP_W'(DEPTH);

  state_t            state, state_next;
  logic [AW-1:0]     head, head_next;
  logic [AW-1:0]     tail, tail_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [CAP_W-1:0]  capacity;
  status_t           status, status_next;

  logic [CMP_W-1:0]  cap_ext, eff_cap;
  logic              full_now, empty_now, ok;
  logic              accept;
  logic [AW-1:0]     head_dec, head_inc, tail_dec, tail_inc;

  assign accept = req_valid && req_ready;

  // Wrapping neighbors of the pointers.
  assign head_dec = (head == '0) ? LAST_IDX : head - AW'(1);
  assign head_inc = (head == LAST_IDX) ? '0 : head + AW'(1);
  assign tail_dec = (tail == '0) ? LAST_IDX : tail - AW'(1);
  assign tail_inc = (tail == LAST_IDX) ? '0 : tail + AW'(1);

  // Effective capacity saturates at the storage depth.
  assign cap_ext   = CMP_W'(capacity);
  assign eff_cap   = (cap_ext > DEPTH_C) ? DEPTH_C : cap_ext;
  assign full_now  = CMP_W'(count) >= eff_cap;
  assign empty_now = count == '0;

  // Apply one operation to the pointers and the count.
  always_comb begin
    head_next = head;
    tail_next = tail;
    count_next = count;
    ok = 1'b0;
    mem_we = 1'b0;
    mem_waddr = tail;
    mem_wdata = req_value;
    unique case (req_action)
      ACT_PUSH_FRONT: begin
        if (!full_now) begin
          ok = 1'b1;
          head_next = head_dec;
          count_next = count + CNT_W'(1);
          mem_we = accept;
          mem_waddr = head_dec;
        end
      end
      ACT_PUSH_BACK: begin
        if (!full_now) begin
          ok = 1'b1;
          tail_next = tail_inc;
          count_next = count + CNT_W'(1);
          mem_we = accept;
          mem_waddr = tail;
        end
      end
      ACT_POP_FRONT: begin
        if (!empty_now) begin
          ok = 1'b1;
          head_next = head_inc;
          count_next = count - CNT_W'(1);
        end
      end
      ACT_POP_BACK: begin
        if (!empty_now) begin
          ok = 1'b1;
          tail_next = tail_dec;
          count_next = count - CNT_W'(1);
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase
    status_next.ok = ok;
    status_next.is_empty = count_next == '0;
    status_next.is_full = CMP_W'(count_next) >= eff_cap;
  end

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (req_valid) state_next = ST_READ;
      ST_READ: state_next = ST_DONE;
      ST_DONE: if (res_taken) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Output decode of the sequencer.
  always_comb begin
    req_ready = 1'b0;
    res_valid = 1'b0;
    unique case (state)
      ST_IDLE: req_ready = 1'b1;
      ST_READ: req_ready = 1'b0;
      ST_DONE: res_valid = 1'b1;
      default: req_ready = 1'b0;
    endcase
  end

  // Reads always follow the committed pointers.
  assign front_addr = head;
  assign rear_addr  = tail_dec;
  assign res_status = status;

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      head     <= '0;
      tail     <= '0;
      count    <= '0;
      capacity <= CAP_RESET;
    end else begin
      state <= state_next;
      if (cfg_wen) begin
        capacity <= cfg_wdata;
      end
      if (accept) begin
        head  <= head_next;
        tail  <= tail_next;
        count <= count_next;
      end
    end
  end

  // Result flags captured with the request.
  always_ff @(posedge clk) begin
    if (accept) begin
      status <= status_next;
    end
  end

endmodule
`default_nettype wire

### sv/bounded_double_ended_queue.sv
// Top level of the bounded double-ended queue.
//
// Requests arrive on the s_ group: s_tuser carries the action (push front,
// push back, pop front, pop back) and s_tdata the word to push. Each request
// yields exactly one result on the m_ group: m_tdata carries the front and
// rear words after the operation (all ones when empty), m_tuser the ok,
// empty and full flags. The user must write capacity through cfg_wen /
// cfg_wdata only while the queue is idle; the block does not enforce this.
// Values above DEPTH act as DEPTH. The entries live in a ring of DEPTH words
// held in two identical RAM copies, one read at the head and one at the slot
// before the tail. A request passes through the states IDLE, READ and DONE:
// acceptance updates the pointers and writes the RAM, READ holds the
// registered RAM read, and DONE moves the result into the output register.
// Requests are taken only in IDLE; one finished result may wait in the
// output register while the next request is processed. If the receiver
// stalls longer, the sequencer holds the next result and s_tready stays low.
// Reset clears the pointers, the count and m_tvalid and sets capacity to 16;
// RAM contents are not cleared and are never read before being written.
`timescale 1ns / 1ps
`default_nettype none
module bounded_double_ended_queue
  import bdq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_wen,
  input  wire logic [4:0]       cfg_wdata,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [31:0]      s_tdata,   // [31:0] value
  input  wire logic [1:0]       s_tuser,   // [1:0] action
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic      [63:0]      m_tdata,   // [31:0] front_value, [63:32] rear_value
  output logic      [2:0]       m_tuser    // [0] ok, [1] is_empty, [2] is_full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [VALUE_W-1:0]  mem_wdata;
  logic [AW-1:0]       front_addr, rear_addr;
  logic [VALUE_W-1:0]  front_word, rear_word;
  logic                res_valid, res_taken;
  status_t             res_status;
  logic [VALUE_W-1:0]  front_sel, rear_sel;

  bdq_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .req_valid (s_tvalid),
    .req_ready (s_tready),
    .req_action(action_t'(s_tuser)),
    .req_value (s_tdata),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .front_addr(front_addr),
    .rear_addr (rear_addr),
    .res_valid (res_valid),
    .res_taken (res_taken),
    .res_status(res_status)
  );

  // Copy read at the head.
  bdq_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(DEPTH)
  ) u_ram_front (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(front_addr),
    .rdata(front_word)
  );

  // Copy read at the slot before the tail.
  bdq_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(DEPTH)
  ) u_ram_rear (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(rear_addr),
    .rdata(rear_word)
  );

  // An empty queue reports all ones for both words.
  assign front_sel = res_status.is_empty ? '1 : front_word;
  assign rear_sel  = res_status.is_empty ? '1 : rear_word;

  // Output register loads whenever it is free or being emptied.
  assign res_taken = res_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_taken) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_taken) begin
      m_tdata <= {rear_sel, front_sel};
      m_tuser <= {res_status.is_full, res_status.is_empty, res_status.ok};
    end
  end

endmodule
`default_nettype wire

### tb/bounded_double_ended_queue_test.sv
// Self-checking testbench for the bounded double-ended queue.
`timescale 1ns / 1ps
module bounded_double_ended_queue_test;
  import bdq_pkg::*;

  localparam int RING = 16;
  localparam logic [31:0] EMPTY_WORD = 32'hFFFF_FFFF;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 60;
  localparam int LONG_HOLD = 80;
  localparam int DRAIN_CYCLES = 20;

  // One result as seen on the output side.
  typedef struct packed {
    logic        ok;
    logic [31:0] front;
    logic [31:0] rear;
    logic        is_empty;
    logic        is_full;
  } deque_view_t;

  // Rows of the directed plan are either requests or capacity writes.
  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    action_t     act;
    logic [31:0] word;
    logic [4:0]  cap;
    logic        typed;
    deque_view_t want;
  } plan_row_t;

  localparam deque_view_t REFUSED_EMPTY = '{1'b0, EMPTY_WORD, EMPTY_WORD, 1'b1, 1'b0};
  localparam deque_view_t REFUSED_NO_ROOM = '{1'b0, EMPTY_WORD, EMPTY_WORD, 1'b1, 1'b1};
  localparam deque_view_t DRAINED = '{1'b1, EMPTY_WORD, EMPTY_WORD, 1'b1, 1'b0};
  localparam deque_view_t FIRST_MAX = '{1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0};
  localparam deque_view_t NO_CHECK = '0;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wen = 1'b0;
  logic [4:0]  cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [2:0]  m_tuser;

  // Predictor state.
  logic [31:0] ring_word [RING];
  int unsigned head_slot = 0;
  int unsigned tail_slot = 0;
  int unsigned live_count = 0;
  logic [4:0]  cap_setting = CAP_RESET;

  deque_view_t pending_views[$];
  int          mismatch_count = 0;
  bit          quiet = 1'b0;
  int          hold_left = 0;

  // Directed plan: empty pops, word extremes, every action, capacity corner cases.
  plan_row_t plan [0:22] = '{
    '{ROW_ITEM, ACT_POP_FRONT,  32'hA5A5_A5A5, 5'd0,  1'b1, REFUSED_EMPTY},
    '{ROW_ITEM, ACT_POP_BACK,   32'h5A5A_5A5A, 5'd0,  1'b1, REFUSED_EMPTY},
    '{ROW_ITEM, ACT_PUSH_BACK,  32'h7FFF_FFFF, 5'd0,  1'b1, FIRST_MAX},
    '{ROW_ITEM, ACT_PUSH_FRONT, 32'h8000_0000, 5'd0,  1'b0, NO_CHECK},
    '{ROW_ITEM, ACT_PUSH_BACK,  32'h0000_0000, 5'd0,  1'b0, NO_CHECK},
    '{ROW_ITEM, ACT_PUSH_FRONT, 32'hFFFF_FFFF, 5'd0,  1'b0, NO_CHECK},
    '{ROW_ITEM, ACT_POP_BACK,   32'h0000_0000, 5'd0,  1'b0, NO_CHECK},
    '{ROW_ITEM, ACT_POP_FRONT,  32'hFFFF_FFFF, 5'd0,  1'b0, NO_CHECK},
    // Two entries are held; a capacity of one leaves the queue over-full.
    '{ROW_CFG,  ACT_PUSH_FRONT, 32'h0000_0000, 5'd1,  1'b0, NO_CHECK},
    '{ROW_ITEM, ACT_PUSH_BACK,  32'h5555_5555, 5'd0,  1'b0, NO_CHECK},
    '{ROW_ITEM, ACT_POP_FRONT,  32'h0000_0000, 5'd0,  1'b0, NO_CHECK},
    '{ROW_ITEM, ACT_PUSH_FRONT, 32'hAAAA_AAAA, 5'd0,  1'b0, NO_CHECK},
    '{ROW_ITEM, ACT_POP_BACK,   32'h0000_0000, 5'd0,  1'b1, DRAINED},
    // Capacity zero: the empty queue is also full and every push is refused.
    '{ROW_CFG,  ACT_PUSH_FRONT, 32'h0000_0000, 5'd0,  1'b0, NO_CHECK},
    '{ROW_ITEM, ACT_PUSH_FRONT, 32'h1234_5678, 5'd0,  1'b1, REFUSED_NO_ROOM},
    '{ROW_ITEM, ACT_PUSH_BACK,  32'h0000_0001, 5'd0,  1'b1, REFUSED_NO_ROOM},
    '{ROW_ITEM, ACT_POP_FRONT,  32'h0000_0000, 5'd0,  1'b1, REFUSED_NO_ROOM},
    // Capacities above the ring size saturate.
    '{ROW_CFG,  ACT_PUSH_FRONT, 32'h0000_0000, 5'd31, 1'b0, NO_CHECK},
    '{ROW_ITEM, ACT_PUSH_BACK,  32'hDEAD_BEEF, 5'd0,  1'b0, NO_CHECK},
    '{ROW_ITEM, ACT_PUSH_FRONT, 32'h0F0F_0F0F, 5'd0,  1'b0, NO_CHECK},
    '{ROW_ITEM, ACT_POP_BACK,   32'h0000_0000, 5'd0,  1'b0, NO_CHECK},
    '{ROW_CFG,  ACT_PUSH_FRONT, 32'h0000_0000, 5'd17, 1'b0, NO_CHECK},
    '{ROW_ITEM, ACT_PUSH_FRONT, 32'hFEDC_BA98, 5'd0,  1'b0, NO_CHECK}
  };

  bounded_double_ended_queue #(
    .DEPTH(RING)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Clock generation.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Applies one request to the predictor and returns the result it should give.
  function automatic deque_view_t apply_deque_op(input action_t act, input logic [31:0] word);
    int unsigned limit;
    deque_view_t v;
    limit = (cap_setting > RING) ? RING : cap_setting;
    v = '0;
    case (act)
      ACT_PUSH_FRONT: begin
        if (live_count < limit) begin
          head_slot = (head_slot + RING - 1) % RING;
          ring_word[head_slot] = word;
          live_count++;
          v.ok = 1'b1;
        end
      end
      ACT_PUSH_BACK: begin
        if (live_count < limit) begin
          ring_word[tail_slot] = word;
          tail_slot = (tail_slot + 1) % RING;
          live_count++;
          v.ok = 1'b1;
        end
      end
      ACT_POP_FRONT: begin
        if (live_count != 0) begin
          head_slot = (head_slot + 1) % RING;
          live_count--;
          v.ok = 1'b1;
        end
      end
      default: begin
        if (live_count != 0) begin
          tail_slot = (tail_slot + RING - 1) % RING;
          live_count--;
          v.ok = 1'b1;
        end
      end
    endcase
    v.is_empty = (live_count == 0);
    v.is_full = (live_count >= limit);
    v.front = v.is_empty ? EMPTY_WORD : ring_word[head_slot];
    v.rear = v.is_empty ? EMPTY_WORD : ring_word[(tail_slot + RING - 1) % RING];
    return v;
  endfunction

  // Words lean toward the extremes so that sign and all-ones cases come often.
  function automatic logic [31:0] draw_word();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic action_t draw_action(input bit push_lean);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < (push_lean ? 75 : 25)) begin
      return ($urandom_range(0, 1) != 0) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
    end
    return ($urandom_range(0, 1) != 0) ? ACT_POP_BACK : ACT_POP_FRONT;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Offers one request after a random gap and returns once it is accepted.
  task automatic send_request(input action_t act, input logic [31:0] word);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= act;
    s_tdata <= word;
    do @(posedge clk); while (!s_tready);
  endtask

  // Sends a request and queues the predicted result, or a fixed one if given.
  task automatic issue_request(input action_t act, input logic [31:0] word,
                               input logic typed, input deque_view_t want);
    deque_view_t v;
    send_request(act, word);
    v = apply_deque_op(act, word);
    pending_views.push_back(typed ? want : v);
  endtask

  // Lets the queue go idle, then writes the capacity register.
  task automatic set_capacity(input logic [4:0] cap);
    s_tvalid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_wen <= 1'b0;
    cap_setting = cap;
  endtask

  // Output side: checks each accepted result and stalls at random.
  initial begin
    int wait_left;
    deque_view_t got;
    deque_view_t want;
    wait_left = 0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        got = '{m_tuser[0], m_tdata[31:0], m_tdata[63:32], m_tuser[1], m_tuser[2]};
        if (pending_views.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual %h", $time, got);
          mismatch_count++;
        end else begin
          want = pending_views.pop_front();
          check_field("ok", 32'(want.ok), 32'(got.ok));
          check_field("front_value", want.front, got.front);
          check_field("rear_value", want.rear, got.rear);
          check_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
          check_field("is_full", 32'(want.is_full), 32'(got.is_full));
        end
        wait_left = quiet ? 0 : $urandom_range(0, 17);
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (wait_left > 0) begin
        wait_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Main stimulus: directed plan, then random phases at several capacities.
  initial begin
    logic [4:0] phase_cap [0:PHASES-1];
    bit push_lean;
    int run_left;
    action_t act;
    phase_cap = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd5, 5'd17, 5'd3, 5'd16, 5'd0, 5'd0};
    phase_cap[8] = 5'($urandom_range(1, 16));
    phase_cap[9] = 5'($urandom_range(0, 31));

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        set_capacity(plan[i].cap);
      end else begin
        issue_request(plan[i].act, plan[i].word, plan[i].typed, plan[i].want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      set_capacity(phase_cap[p]);
      quiet = (p % 3 == 2);
      // Hold the output side for a long stretch so that the input stalls.
      if (p == 2) hold_left = LONG_HOLD;
      push_lean = 1'b1;
      run_left = $urandom_range(4, 24);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (run_left == 0) begin
          push_lean = !push_lean;
          run_left = $urandom_range(4, 24);
        end
        run_left--;
        act = draw_action(push_lean);
        issue_request(act, draw_word(), 1'b0, NO_CHECK);
      end
    end

    // Drain and allow for any stray result.
    s_tvalid <= 1'b0;
    quiet = 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_views.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

### files.f
sv/bdq_pkg.sv
sv/bdq_ram.sv
sv/bdq_ctrl.sv
sv/bounded_double_ended_queue.sv
tb/bounded_double_ended_queue_test.sv
